// ===== sv/lcr_pkg.sv =====
// Shared types and constants for the load-cell converter serial reader.
// No dependencies; compiled first.
package lcr_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int HALF_W      = 16;
    localparam int TIMEOUT_W   = 24;
    localparam int GAIN_W      = 2;
    localparam int BITCNT_W    = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    // command codes carried by each tick
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_DOWN = 2'd2;
    localparam logic [1:0] OP_UP   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PULSES = 2'd2;

    localparam logic [HALF_W-1:0]    HALF_RESET    = 16'd1;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd1000000;
    localparam logic [GAIN_W-1:0]    GAIN_RESET    = 2'd3;

    typedef struct packed {
        logic [HALF_W-1:0]    half_period_ticks;
        logic [TIMEOUT_W-1:0] timeout_ticks;
        logic [GAIN_W-1:0]    gain_pulses;
    } t_cfg;

    typedef struct packed {
        logic                          clock_level;
        logic                          sample_valid;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          status;
        logic                          busy_res;
        logic                          data_ready;
    } t_result;

endpackage

// ===== sv/lcr_in_if.sv =====
// Input channel of the serial reader: one tick word (command, data line level).
// Depends on nothing.
interface lcr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic       data_level;

    modport source (output valid, output op, output data_level, input ready);
    modport sink   (input valid, input op, input data_level, output ready);
endinterface

// ===== sv/lcr_out_if.sv =====
// Output channel of the serial reader: one result word per tick.
// Depends on nothing.
interface lcr_out_if;
    logic               valid;
    logic               ready;
    logic               clock_level;
    logic               sample_valid;
    logic signed [23:0] sample;
    logic               status;
    logic               busy_res;
    logic               data_ready;

    modport source (output valid, output clock_level, output sample_valid, output sample,
                    output status, output busy_res, output data_ready, input ready);
    modport sink   (input valid, input clock_level, input sample_valid, input sample,
                    input status, input busy_res, input data_ready, output ready);
endinterface

// ===== sv/lcr_core.sv =====
// Clock-line sequencer state and single-tick next-state logic.
// Depends on lcr_pkg.
module lcr_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [1:0]       i_op,
    input  logic             i_data_level,
    input  lcr_pkg::t_cfg    i_cfg,
    output lcr_pkg::t_result o_res
);
    import lcr_pkg::*;

    typedef enum logic [2:0] {PH_IDLE, PH_WAIT, PH_HIGH, PH_LOW, PH_DOWN} t_phase;

    t_phase                 r_phase,      n_phase;
    logic [BITCNT_W-1:0]    r_bit_count,  n_bit_count;
    logic [HALF_W-1:0]      r_half_timer, n_half_timer;
    logic [TIMEOUT_W-1:0]   r_wait_count, n_wait_count;
    logic [SAMPLE_BITS-1:0] r_shift_bits, n_shift_bits;
    logic                   r_clock_out,  n_clock_out;
    logic                   r_error_flag, n_error_flag;

    logic [HALF_W-1:0]   half;
    logic [GAIN_W-1:0]   extra;
    logic [BITCNT_W-1:0] total;
    logic [HALF_W-1:0]   ht_inc;
    logic [BITCNT_W-1:0] bc_inc;
    logic                valid;
    logic [SAMPLE_BITS-1:0] result;

    always_comb begin
        half  = (i_cfg.half_period_ticks == '0) ? HALF_W'(1) : i_cfg.half_period_ticks;
        extra = (i_cfg.gain_pulses == '0) ? GAIN_W'(1) : i_cfg.gain_pulses;
        total = BITCNT_W'(SAMPLE_BITS) + {{(BITCNT_W-GAIN_W){1'b0}}, extra};

        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_half_timer = r_half_timer;
        n_wait_count = r_wait_count;
        n_shift_bits = r_shift_bits;
        n_clock_out  = r_clock_out;
        n_error_flag = r_error_flag;
        ht_inc       = r_half_timer + HALF_W'(1);
        bc_inc       = r_bit_count + BITCNT_W'(1);
        valid        = 1'b0;
        result       = '0;

        // commands only act outside a read
        if (r_phase == PH_IDLE || r_phase == PH_DOWN) begin
            if (i_op == OP_READ && r_phase == PH_IDLE) begin
                n_phase      = PH_WAIT;
                n_wait_count = '0;
            end else if (i_op == OP_DOWN) begin
                n_phase      = PH_DOWN;
                n_clock_out  = 1'b1;
                n_error_flag = 1'b0;
            end else if (i_op == OP_UP) begin
                n_phase      = PH_IDLE;
                n_clock_out  = 1'b0;
                n_error_flag = 1'b0;
            end
        end

        unique case (n_phase)
            PH_WAIT: begin
                if (!i_data_level) begin
                    n_phase      = PH_HIGH;
                    n_clock_out  = 1'b1;
                    n_half_timer = '0;
                    n_bit_count  = '0;
                    n_shift_bits = '0;
                end else if (n_wait_count >= i_cfg.timeout_ticks) begin
                    n_phase      = PH_IDLE;
                    n_clock_out  = 1'b0;
                    n_error_flag = 1'b1;
                end else begin
                    n_wait_count = n_wait_count + TIMEOUT_W'(1);
                end
            end
            PH_HIGH: begin
                n_half_timer = ht_inc;
                if (ht_inc >= half) begin
                    n_phase      = PH_LOW;
                    n_clock_out  = 1'b0;
                    n_half_timer = '0;
                end
            end
            PH_LOW: begin
                // data bit sampled on the first tick after the falling edge
                if (r_half_timer == '0 && r_bit_count < BITCNT_W'(SAMPLE_BITS)) begin
                    n_shift_bits = {r_shift_bits[SAMPLE_BITS-2:0], i_data_level};
                end
                n_half_timer = ht_inc;
                if (ht_inc >= half) begin
                    n_half_timer = '0;
                    n_bit_count  = bc_inc;
                    if (bc_inc >= total) begin
                        n_phase      = PH_IDLE;
                        valid        = 1'b1;
                        result       = n_shift_bits;
                        n_error_flag = 1'b0;
                        n_bit_count  = '0;
                    end else begin
                        n_phase     = PH_HIGH;
                        n_clock_out = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        o_res.clock_level  = n_clock_out;
        o_res.sample_valid = valid;
        o_res.sample       = $signed(result);
        o_res.status       = n_error_flag;
        o_res.busy_res     = (n_phase == PH_WAIT || n_phase == PH_HIGH || n_phase == PH_LOW);
        o_res.data_ready   = !i_data_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_count  <= '0;
            r_half_timer <= '0;
            r_wait_count <= '0;
            r_shift_bits <= '0;
            r_clock_out  <= 1'b0;
            r_error_flag <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_half_timer <= n_half_timer;
            r_wait_count <= n_wait_count;
            r_shift_bits <= n_shift_bits;
            r_clock_out  <= n_clock_out;
            r_error_flag <= n_error_flag;
        end
    end

endmodule

// ===== sv/load_cell_adc_serial_reader.sv =====
// Serial reader for a 24-bit load-cell converter. Every input word is one timing tick
// (command plus sampled data-line level) and yields exactly one result word carrying the
// clock-line level, status and, on the tick a read completes, the signed sample. Words
// enter an input register and the result is computed in one pass into an output register,
// so one word is taken every clock cycle unless the output is stalled, which holds the
// input word in its register. Configuration writes must be made while idle.
module load_cell_adc_serial_reader (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    lcr_in_if.sink                                   i_in_ch,
    lcr_out_if.source                                o_out_ch,
    input  logic                                     i_cfg_we,
    input  logic [lcr_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [lcr_pkg::CFG_DATA_W-1:0]           i_cfg_data
);
    import lcr_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    logic [1:0] r_op;
    logic    r_dl;
    logic    r_out_valid;
    t_result r_out;
    t_result step_res;
    logic    step;

    assign step           = r_in_valid && (!r_out_valid || o_out_ch.ready);
    assign i_in_ch.ready  = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks <= HALF_RESET;
            r_cfg.timeout_ticks     <= TIMEOUT_RESET;
            r_cfg.gain_pulses       <= GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_HALF_PERIOD: r_cfg.half_period_ticks <= i_cfg_data[HALF_W-1:0];
                REG_TIMEOUT:     r_cfg.timeout_ticks     <= i_cfg_data[TIMEOUT_W-1:0];
                REG_GAIN_PULSES: r_cfg.gain_pulses       <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_in_valid <= i_in_ch.valid;
        end
        if (i_in_ch.ready && i_in_ch.valid) begin
            r_op <= i_in_ch.op;
            r_dl <= i_in_ch.data_level;
        end
    end

    lcr_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_op         (r_op),
        .i_data_level (r_dl),
        .i_cfg        (r_cfg),
        .o_res        (step_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
        if (step) begin
            r_out <= step_res;
        end
    end

    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.clock_level  = r_out.clock_level;
    assign o_out_ch.sample_valid = r_out.sample_valid;
    assign o_out_ch.sample       = r_out.sample;
    assign o_out_ch.status       = r_out.status;
    assign o_out_ch.busy_res     = r_out.busy_res;
    assign o_out_ch.data_ready   = r_out.data_ready;

    // a completed read is never busy and never flagged as timed out
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.sample_valid |-> !r_out.busy_res && !r_out.status)
        else $error("completed sample with busy or timeout");

    // sample field is zero unless a read completed
    a_sample_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.sample_valid |-> r_out.sample == '0)
        else $error("sample nonzero without completion");

    // a processed word always produces a result word next cycle
    a_step_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("result word lost");

    // an accepted word is held in the input register next cycle
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ch.valid && i_in_ch.ready |=> r_in_valid)
        else $error("accepted word dropped");

endmodule
